>>> sv/lfsm_pkg.sv
// Package for the latest-frame slot manager.
// Holds command and status codes, the controller state type and the
// control/status bundles shared by the controller, datapath and top level.
package lfsm_pkg;

  // Command codes carried on the cmd field.
  localparam logic [2:0] CMD_PUBLISH = 3'd0;
  localparam logic [2:0] CMD_FAILURE = 3'd1;
  localparam logic [2:0] CMD_ACQUIRE = 3'd2;
  localparam logic [2:0] CMD_RELEASE = 3'd3;
  localparam logic [2:0] CMD_STOP    = 3'd4;

  // Status codes returned with every result.
  localparam logic [2:0] STS_ACCEPTED = 3'd0;
  localparam logic [2:0] STS_GRANTED  = 3'd1;
  localparam logic [2:0] STS_NO_FRAME = 3'd2;
  localparam logic [2:0] STS_FATAL    = 3'd3;
  localparam logic [2:0] STS_DROPPED  = 3'd4;
  localparam logic [2:0] STS_HALTED   = 3'd5;

  // Failure limit used at reset and when the register holds zero.
  localparam logic [7:0] FAIL_DEFAULT = 8'd30;

  // Configuration register indexes.
  localparam logic REG_MAX_FAILURES = 1'b0;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic out_free;
    logic fatal_flag;
    logic running_flag;
  } dp_status_t;

endpackage

>>> sv/lfsm_ctrl.sv
// Controller state machine for the latest-frame slot manager.
// Sequences capture and execute of one command; depends on lfsm_pkg.
module lfsm_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  lfsm_pkg::dp_status_t   dp_status,
  output logic                   in_stall,
  output lfsm_pkg::ctrl_cmd_t    ctrl
);

  lfsm_pkg::state_t state;
  lfsm_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfsm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: take a command, then execute it once the result register is free.
  always_comb begin
    state_next = state;
    unique case (state)
      lfsm_pkg::ST_IDLE: begin
        if (in_valid) state_next = lfsm_pkg::ST_EXEC;
      end
      lfsm_pkg::ST_EXEC: begin
        if (dp_status.out_free) state_next = lfsm_pkg::ST_IDLE;
      end
      default: state_next = lfsm_pkg::ST_IDLE;
    endcase
  end

  // Outputs to the handshake and the datapath.
  always_comb begin
    in_stall     = 1'b1;
    ctrl.capture = 1'b0;
    ctrl.execute = 1'b0;
    unique case (state)
      lfsm_pkg::ST_IDLE: begin
        in_stall     = 1'b0;
        ctrl.capture = in_valid;
      end
      lfsm_pkg::ST_EXEC: begin
        ctrl.execute = dp_status.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

>>> sv/lfsm_datapath.sv
// Datapath for the latest-frame slot manager: slot flags, slot stores,
// counters, slot selection and the result register. Depends on lfsm_pkg.
module lfsm_datapath #(
  parameter int SLOT_COUNT = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lfsm_pkg::ctrl_cmd_t   ctrl,
  output lfsm_pkg::dp_status_t  dp_status,
  input  logic [7:0]            max_failures,
  input  logic [2:0]            cmd,
  input  logic [31:0]           capture_tag,
  input  logic [3:0]            slot_sel,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [2:0]            status,
  output logic [3:0]            slot_out,
  output logic [31:0]           frame_tag,
  output logic [31:0]           sequence_res,
  output logic [31:0]           drop_total,
  output logic                  fatal
);

  localparam int SW = $clog2(SLOT_COUNT);
  localparam int CW = $clog2(SLOT_COUNT + 1);

  // Captured command.
  logic [2:0]  cmd_q;
  logic [31:0] capture_tag_q;
  logic [3:0]  slot_sel_q;

  // Slot flags and stores.
  logic [SLOT_COUNT-1:0] slot_valid, slot_valid_next;
  logic [SLOT_COUNT-1:0] slot_busy, slot_busy_next;
  logic [31:0]           slot_sequence [SLOT_COUNT];
  logic [31:0]           slot_tag [SLOT_COUNT];

  // Scalar state.
  logic [SW-1:0] newest_slot, newest_slot_next;
  logic          newest_present, newest_present_next;
  logic [31:0]   drop_count, drop_count_next;
  logic [31:0]   next_sequence, next_sequence_next;
  logic [31:0]   taken_sequence, taken_sequence_next;
  logic          fatal_flag, fatal_flag_next;
  logic          running_flag, running_flag_next;
  logic [7:0]    fail_run, fail_run_next;

  // Selection and result signals.
  logic [SW-1:0]         empty_idx, nonbusy_idx, pick_idx, keep_idx;
  logic                  empty_hit, nonbusy_hit, pick_hit, pick_drop;
  logic [SLOT_COUNT-1:0] keep_mask, pick_mask, stale_mask, release_mask;
  logic [CW-1:0]         stale_cnt, drop_add;
  logic                  acq_ok, slot_we;
  logic [7:0]            fail_limit, fail_inc;
  logic [2:0]            res_status;
  logic [3:0]            res_slot;
  logic [31:0]           res_tag, res_seq;

  // Capture the command fields on input transfer.
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_q         <= cmd;
      capture_tag_q <= capture_tag;
      slot_sel_q    <= slot_sel;
    end
  end

  // Lowest slot that is free and empty, and lowest slot that is not busy.
  always_comb begin
    empty_idx   = '0;
    empty_hit   = 1'b0;
    nonbusy_idx = '0;
    nonbusy_hit = 1'b0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!slot_busy[i] && !slot_valid[i]) begin
        empty_idx = SW'(i);
        empty_hit = 1'b1;
      end
      if (!slot_busy[i]) begin
        nonbusy_idx = SW'(i);
        nonbusy_hit = 1'b1;
      end
    end
  end

  // Write slot choice for a publish; overwriting a waiting frame counts a drop.
  always_comb begin
    pick_idx  = empty_idx;
    pick_hit  = 1'b1;
    pick_drop = 1'b0;
    if (empty_hit) begin
      pick_idx = empty_idx;
    end else if (newest_present && !slot_busy[newest_slot]) begin
      pick_idx  = newest_slot;
      pick_drop = 1'b1;
    end else if (nonbusy_hit) begin
      pick_idx  = nonbusy_idx;
      pick_drop = slot_valid[nonbusy_idx];
    end else begin
      pick_hit  = 1'b0;
      pick_drop = 1'b1;
    end
  end

  // An acquire only grants a frame the reader has not seen, unless stopped.
  assign acq_ok = newest_present && slot_valid[newest_slot] &&
                  !(running_flag && (slot_sequence[newest_slot] == taken_sequence));

  assign keep_idx = (cmd_q == lfsm_pkg::CMD_ACQUIRE) ? newest_slot : pick_idx;

  // Stale frames: waiting, not busy, and not the slot being kept.
  always_comb begin
    stale_cnt = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      keep_mask[i]    = (SW'(i) == keep_idx);
      pick_mask[i]    = (SW'(i) == pick_idx);
      release_mask[i] = (4'(i) == slot_sel_q);
      stale_mask[i]   = slot_valid[i] && !slot_busy[i] && !keep_mask[i];
      stale_cnt       = stale_cnt + CW'(stale_mask[i]);
    end
  end

  assign drop_add   = CW'(pick_drop) + (pick_hit ? stale_cnt : CW'(0));
  assign fail_limit = (max_failures == 8'd0) ? lfsm_pkg::FAIL_DEFAULT : max_failures;
  assign fail_inc   = (fail_run == 8'hFF) ? fail_run : fail_run + 8'd1;

  // Command execution: next state and result fields.
  always_comb begin
    slot_valid_next     = slot_valid;
    slot_busy_next      = slot_busy;
    newest_slot_next    = newest_slot;
    newest_present_next = newest_present;
    drop_count_next     = drop_count;
    next_sequence_next  = next_sequence;
    taken_sequence_next = taken_sequence;
    fatal_flag_next     = fatal_flag;
    running_flag_next   = running_flag;
    fail_run_next       = fail_run;
    slot_we             = 1'b0;
    res_status          = lfsm_pkg::STS_ACCEPTED;
    res_slot            = 4'd0;
    res_tag             = 32'd0;
    res_seq             = 32'd0;
    case (cmd_q)
      lfsm_pkg::CMD_PUBLISH: begin
        if (!running_flag) begin
          res_status = lfsm_pkg::STS_HALTED;
        end else begin
          fail_run_next   = 8'd0;
          drop_count_next = drop_count + 32'(drop_add);
          if (pick_hit) begin
            slot_we             = 1'b1;
            next_sequence_next  = next_sequence + 32'd1;
            slot_valid_next     = (slot_valid & ~stale_mask) | pick_mask;
            newest_slot_next    = pick_idx;
            newest_present_next = 1'b1;
            res_slot            = 4'(pick_idx);
            res_tag             = capture_tag_q;
            res_seq             = next_sequence;
          end else begin
            res_status = lfsm_pkg::STS_DROPPED;
          end
        end
      end
      lfsm_pkg::CMD_FAILURE: begin
        if (!running_flag) begin
          res_status = lfsm_pkg::STS_HALTED;
        end else begin
          fail_run_next = fail_inc;
          if (fail_inc >= fail_limit) begin
            fatal_flag_next   = 1'b1;
            running_flag_next = 1'b0;
            res_status        = lfsm_pkg::STS_FATAL;
          end
        end
      end
      lfsm_pkg::CMD_ACQUIRE: begin
        if (fatal_flag) begin
          res_status = lfsm_pkg::STS_FATAL;
        end else if (!acq_ok) begin
          res_status = lfsm_pkg::STS_NO_FRAME;
        end else begin
          drop_count_next     = drop_count + 32'(stale_cnt);
          slot_valid_next     = slot_valid & ~stale_mask & ~keep_mask;
          slot_busy_next      = slot_busy | keep_mask;
          taken_sequence_next = slot_sequence[newest_slot];
          newest_present_next = 1'b0;
          newest_slot_next    = '0;
          res_status          = lfsm_pkg::STS_GRANTED;
          res_slot            = 4'(newest_slot);
          res_tag             = slot_tag[newest_slot];
          res_seq             = slot_sequence[newest_slot];
        end
      end
      lfsm_pkg::CMD_RELEASE: begin
        // Selections beyond the slot count match no bit of the mask.
        slot_busy_next = slot_busy & ~release_mask;
        res_slot       = slot_sel_q;
      end
      lfsm_pkg::CMD_STOP: begin
        running_flag_next = 1'b0;
      end
      default: begin
        res_status = lfsm_pkg::STS_ACCEPTED;
      end
    endcase
  end

  // Control state, updated when a command executes.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid     <= '0;
      slot_busy      <= '0;
      newest_slot    <= '0;
      newest_present <= 1'b0;
      drop_count     <= 32'd0;
      next_sequence  <= 32'd1;
      taken_sequence <= 32'd0;
      fatal_flag     <= 1'b0;
      running_flag   <= 1'b1;
      fail_run       <= 8'd0;
    end else if (ctrl.execute) begin
      slot_valid     <= slot_valid_next;
      slot_busy      <= slot_busy_next;
      newest_slot    <= newest_slot_next;
      newest_present <= newest_present_next;
      drop_count     <= drop_count_next;
      next_sequence  <= next_sequence_next;
      taken_sequence <= taken_sequence_next;
      fatal_flag     <= fatal_flag_next;
      running_flag   <= running_flag_next;
      fail_run       <= fail_run_next;
    end
  end

  // Slot stores, written by a successful publish.
  always_ff @(posedge clk) begin
    if (ctrl.execute && slot_we) begin
      slot_sequence[pick_idx] <= next_sequence;
      slot_tag[pick_idx]      <= capture_tag_q;
    end
  end

  // Result register; a new result may load in the cycle the old one transfers.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.execute) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.execute) begin
      status       <= res_status;
      slot_out     <= res_slot;
      frame_tag    <= res_tag;
      sequence_res <= res_seq;
      drop_total   <= drop_count_next;
      fatal        <= fatal_flag_next;
    end
  end

  assign dp_status.out_free     = !out_valid || !out_stall;
  assign dp_status.fatal_flag   = fatal_flag;
  assign dp_status.running_flag = running_flag;

endmodule

>>> sv/latest_frame_slot_manager.sv
// Latest-frame slot manager: keeps only the newest frame among SLOT_COUNT slots.
// A command is captured on transfer and executed once the result register is free;
// the result is registered at execution. The capture/execute controller takes no new
// command until the current one has executed; a stalled result holds the next command
// in its execute step.
// Reset (rst, synchronous, active high) clears slot flags and counters at once,
// sets the sequence counter to one and the failure limit to 30.
module latest_frame_slot_manager #(
  parameter int SLOT_COUNT = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [31:0] capture_tag,
  input  logic [3:0]  slot_sel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [3:0]  slot_out,
  output logic [31:0] frame_tag,
  output logic [31:0] sequence_res,
  output logic [31:0] drop_total,
  output logic        fatal
);

  logic [7:0]           max_failures;
  logic                 cfg_write;
  lfsm_pkg::ctrl_cmd_t  ctrl;
  lfsm_pkg::dp_status_t dp_status;

  // Configuration register, written in the access phase of a transfer.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_failures <= lfsm_pkg::FAIL_DEFAULT;
    end else if (cfg_write && (paddr[2] == lfsm_pkg::REG_MAX_FAILURES)) begin
      max_failures <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == lfsm_pkg::REG_MAX_FAILURES) ? {24'd0, max_failures} : 32'd0;

  // Controller.
  lfsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .dp_status (dp_status),
    .in_stall  (in_stall),
    .ctrl      (ctrl)
  );

  // Datapath.
  lfsm_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .dp_status    (dp_status),
    .max_failures (max_failures),
    .cmd          (cmd),
    .capture_tag  (capture_tag),
    .slot_sel     (slot_sel),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .status       (status),
    .slot_out     (slot_out),
    .frame_tag    (frame_tag),
    .sequence_res (sequence_res),
    .drop_total   (drop_total),
    .fatal        (fatal)
  );

`ifndef ASSERT_OFF
  // Once fatal, the block stays fatal until reset.
  a_fatal_sticky: assert property (@(posedge clk) disable iff (rst)
    dp_status.fatal_flag |=> dp_status.fatal_flag)
    else $error("fatal flag cleared without reset");

  // A fatal block is never running.
  a_fatal_halted: assert property (@(posedge clk) disable iff (rst)
    dp_status.fatal_flag |-> !dp_status.running_flag)
    else $error("fatal block still running");

  // A command transfer keeps the input side stalled for the execute step.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice in a row");

  // A fatal status always comes with the fatal flag set.
  a_fatal_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == lfsm_pkg::STS_FATAL)) |-> fatal)
    else $error("fatal status without fatal flag");
`endif

endmodule

>>> tb/lfsm_checker.sv
// Result checker for the latest-frame slot manager.
// Watches the command, result and register ports, predicts every result
// from its own copy of the slot state and compares it. Depends on lfsm_pkg.
module lfsm_checker #(
  parameter int SLOT_COUNT = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [31:0] capture_tag,
  input  logic [3:0]  slot_sel,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  status,
  input  logic [3:0]  slot_out,
  input  logic [31:0] frame_tag,
  input  logic [31:0] sequence_res,
  input  logic [31:0] drop_total,
  input  logic        fatal,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Byte address of the failure limit register.
  localparam logic [2:0] MAX_FAIL_ADDR = {lfsm_pkg::REG_MAX_FAILURES, 2'b00};

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [31:0] tag;
    logic [31:0] seq;
    logic [31:0] drops;
    logic        fatal;
  } slot_result_t;

  // Predicted slot state.
  logic [SLOT_COUNT-1:0] full_q = '0;
  logic [SLOT_COUNT-1:0] held_q = '0;
  logic [31:0] seq_tab [SLOT_COUNT];
  logic [31:0] tag_tab [SLOT_COUNT];
  logic [3:0]  latest_idx = '0;
  logic        latest_vld = 1'b0;
  logic [31:0] drops = '0;
  logic [31:0] seq_next = 32'd1;
  logic [31:0] seq_taken = '0;
  logic        fatal_st = 1'b0;
  logic        run_st = 1'b1;
  logic [7:0]  fail_cnt = '0;
  logic [7:0]  limit_reg = lfsm_pkg::FAIL_DEFAULT;

  slot_result_t expected_q[$];
  int fail_total = 0;

  // Invalidate every unheld frame except the one being kept, counting drops.
  function automatic void discard_stale(input int keep);
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (i != keep && !held_q[i] && full_q[i]) begin
        full_q[i] = 1'b0;
        drops = drops + 32'd1;
      end
    end
  endfunction

  // Apply one command to the predicted state and return its result.
  function automatic slot_result_t predict_command(input logic [2:0] c,
                                                   input logic [31:0] fid,
                                                   input logic [3:0] sel);
    slot_result_t r;
    int pick;
    int n;
    logic ok;
    logic [7:0] lim;
    r = '0;
    r.status = lfsm_pkg::STS_ACCEPTED;
    case (c)
      lfsm_pkg::CMD_PUBLISH: begin
        if (!run_st) begin
          r.status = lfsm_pkg::STS_HALTED;
        end else begin
          fail_cnt = '0;
          // Empty slot first, then the unheld newest, then any unheld slot.
          pick = SLOT_COUNT;
          for (int i = 0; i < SLOT_COUNT; i++)
            if (pick == SLOT_COUNT && !held_q[i] && !full_q[i]) pick = i;
          if (pick == SLOT_COUNT && latest_vld && latest_idx < SLOT_COUNT &&
              !held_q[latest_idx]) begin
            drops = drops + 32'd1;
            pick = int'(latest_idx);
          end
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (pick == SLOT_COUNT && !held_q[i]) begin
              if (full_q[i]) drops = drops + 32'd1;
              pick = i;
            end
          end
          if (pick == SLOT_COUNT) begin
            drops = drops + 32'd1;
            r.status = lfsm_pkg::STS_DROPPED;
          end else begin
            seq_tab[pick] = seq_next;
            tag_tab[pick] = fid;
            full_q[pick] = 1'b1;
            latest_idx = 4'(pick);
            latest_vld = 1'b1;
            discard_stale(pick);
            r.slot = 4'(pick);
            r.tag = fid;
            r.seq = seq_next;
            seq_next = seq_next + 32'd1;
          end
        end
      end
      lfsm_pkg::CMD_FAILURE: begin
        if (!run_st) begin
          r.status = lfsm_pkg::STS_HALTED;
        end else begin
          lim = (limit_reg != 8'd0) ? limit_reg : lfsm_pkg::FAIL_DEFAULT;
          if (fail_cnt != 8'hFF) fail_cnt = fail_cnt + 8'd1;
          if (fail_cnt >= lim) begin
            fatal_st = 1'b1;
            run_st = 1'b0;
            r.status = lfsm_pkg::STS_FATAL;
          end
        end
      end
      lfsm_pkg::CMD_ACQUIRE: begin
        if (fatal_st) begin
          r.status = lfsm_pkg::STS_FATAL;
        end else begin
          n = int'(latest_idx);
          ok = latest_vld && n < SLOT_COUNT && full_q[n];
          // While running, a frame already handed out is not new.
          if (ok && run_st && seq_tab[n] == seq_taken) ok = 1'b0;
          if (!ok) begin
            r.status = lfsm_pkg::STS_NO_FRAME;
          end else begin
            discard_stale(n);
            held_q[n] = 1'b1;
            full_q[n] = 1'b0;
            seq_taken = seq_tab[n];
            latest_vld = 1'b0;
            latest_idx = '0;
            r.status = lfsm_pkg::STS_GRANTED;
            r.slot = 4'(n);
            r.tag = tag_tab[n];
            r.seq = seq_tab[n];
          end
        end
      end
      lfsm_pkg::CMD_RELEASE: begin
        if (sel < SLOT_COUNT) held_q[sel] = 1'b0;
        r.slot = sel;
      end
      lfsm_pkg::CMD_STOP: begin
        run_st = 1'b0;
      end
      default: ;
    endcase
    r.drops = drops;
    r.fatal = fatal_st;
    return r;
  endfunction

  task automatic compare_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname, want, got);
      fail_total++;
    end
  endtask

  // Track register writes, predict each command transfer, check each result transfer.
  always @(posedge clk) begin
    slot_result_t want;
    if (rst) begin
      full_q = '0;
      held_q = '0;
      latest_idx = '0;
      latest_vld = 1'b0;
      drops = '0;
      seq_next = 32'd1;
      seq_taken = '0;
      fatal_st = 1'b0;
      run_st = 1'b1;
      fail_cnt = '0;
      limit_reg = lfsm_pkg::FAIL_DEFAULT;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == MAX_FAIL_ADDR)
        limit_reg = pwdata[7:0];
      if (in_valid && !in_stall)
        expected_q.push_back(predict_command(cmd, capture_tag, slot_sel));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual status %0d slot %0d",
                   $time, status, slot_out);
          fail_total++;
        end else begin
          want = expected_q.pop_front();
          compare_field("status", 32'(want.status), 32'(status));
          compare_field("slot_out", 32'(want.slot), 32'(slot_out));
          compare_field("frame_tag", want.tag, frame_tag);
          compare_field("sequence_res", want.seq, sequence_res);
          compare_field("drop_total", want.drops, drop_total);
          compare_field("fatal", 32'(want.fatal), 32'(fatal));
        end
      end
    end
    pending <= expected_q.size();
    errors <= fail_total;
  end

endmodule

>>> tb/tb_latest_frame_slot_manager.sv
// Testbench top for the latest-frame slot manager.
// Drives commands, register writes and result back-pressure; the checker in
// lfsm_checker.sv predicts and compares. Depends on lfsm_pkg and the block.
module tb_latest_frame_slot_manager;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 3;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [2:0] MAX_FAIL_ADDR = {lfsm_pkg::REG_MAX_FAILURES, 2'b00};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  cmd = lfsm_pkg::CMD_STOP;
  logic [31:0] capture_tag = '0;
  logic [3:0]  slot_sel = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [3:0]  slot_out;
  logic [31:0] frame_tag;
  logic [31:0] sequence_res;
  logic [31:0] drop_total;
  logic        fatal;
  int          errors;
  int          pending;

  int          cycles = 0;
  int          items_sent = 0;
  int          fails_run = 0;
  int          fail_limit = 30;
  logic        quiet = 1'b0;

  always #5 clk = ~clk;

  latest_frame_slot_manager #(.SLOT_COUNT(SLOTS)) dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .cmd, .capture_tag, .slot_sel,
    .out_valid, .out_stall, .status, .slot_out, .frame_tag, .sequence_res,
    .drop_total, .fatal
  );

  lfsm_checker #(.SLOT_COUNT(SLOTS)) u_checker (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid, .in_stall, .cmd, .capture_tag, .slot_sel,
    .out_valid, .out_stall, .status, .slot_out, .frame_tag, .sequence_res,
    .drop_total, .fatal, .errors, .pending
  );

  // Run-length guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: a random stall before each transfer, none in quiet stretches.
  initial begin
    int gap;
    @(posedge clk);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // One command transfer after a random gap; valid stays high across back-to-back items.
  task automatic send_item(input logic [2:0] c, input logic [31:0] fid,
                           input logic [3:0] sel);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd <= c;
    capture_tag <= fid;
    slot_sel <= sel;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (c == lfsm_pkg::CMD_PUBLISH) fails_run = 0;
    if (c == lfsm_pkg::CMD_FAILURE) fails_run++;
    items_sent++;
    if (items_sent % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
  endtask

  // Hold off until every predicted result has arrived, plus the block latency.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly publish/acquire/release traffic; failure bursts stop short of the limit.
  task automatic random_item();
    int pick;
    int burst;
    logic [31:0] fid;
    logic [3:0] sel;
    pick = $urandom_range(0, 99);
    fid = $urandom();
    case ($urandom_range(0, 15))
      0: fid = '0;
      1: fid = '1;
      default: ;
    endcase
    if ($urandom_range(0, 7) == 0) sel = 4'($urandom_range(0, 15));
    else sel = 4'($urandom_range(0, SLOTS - 1));
    if (pick < 38) begin
      send_item(lfsm_pkg::CMD_PUBLISH, fid, sel);
    end else if (pick < 63) begin
      send_item(lfsm_pkg::CMD_ACQUIRE, fid, sel);
    end else if (pick < 85) begin
      send_item(lfsm_pkg::CMD_RELEASE, fid, sel);
    end else if (pick < 96) begin
      burst = $urandom_range(1, 6);
      if (fail_limit <= 30 && $urandom_range(0, 7) == 0) burst = fail_limit;
      for (int i = 0; i < burst; i++) begin
        if (fails_run + 1 >= fail_limit) break;
        send_item(lfsm_pkg::CMD_FAILURE, $urandom(), 4'($urandom_range(0, 15)));
      end
    end else begin
      send_item(3'($urandom_range(5, 7)), fid, sel);
    end
  endtask

  task automatic random_phase(input int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) random_item();
  endtask

  // Main stimulus.
  initial begin
    int limit_val;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty acquire, tag extremes, all slots held, reuse of the newest.
    send_item(lfsm_pkg::CMD_ACQUIRE, 32'h0, 4'd0);
    send_item(lfsm_pkg::CMD_PUBLISH, 32'h0000_0000, 4'd0);
    send_item(lfsm_pkg::CMD_PUBLISH, 32'hFFFF_FFFF, 4'd15);
    send_item(lfsm_pkg::CMD_ACQUIRE, 32'h0, 4'd0);
    send_item(lfsm_pkg::CMD_ACQUIRE, 32'h0, 4'd0);
    send_item(lfsm_pkg::CMD_PUBLISH, 32'h1234_5678, 4'd0);
    send_item(lfsm_pkg::CMD_ACQUIRE, 32'h0, 4'd0);
    send_item(lfsm_pkg::CMD_PUBLISH, 32'hA5A5_A5A5, 4'd0);
    send_item(lfsm_pkg::CMD_ACQUIRE, 32'h0, 4'd0);
    send_item(lfsm_pkg::CMD_PUBLISH, 32'hDEAD_BEEF, 4'd0);
    send_item(lfsm_pkg::CMD_RELEASE, 32'h0, 4'd15);
    send_item(lfsm_pkg::CMD_RELEASE, 32'h0, 4'(SLOTS));
    send_item(lfsm_pkg::CMD_RELEASE, 32'h0, 4'd1);
    send_item(lfsm_pkg::CMD_PUBLISH, 32'h0F0F_0F0F, 4'd0);
    send_item(lfsm_pkg::CMD_PUBLISH, 32'hF0F0_F0F0, 4'd0);
    send_item(lfsm_pkg::CMD_FAILURE, 32'h0, 4'd0);
    send_item(lfsm_pkg::CMD_FAILURE, 32'h0, 4'd0);
    send_item(lfsm_pkg::CMD_PUBLISH, 32'h5A5A_5A5A, 4'd0);
    send_item(3'd5, 32'hFFFF_FFFF, 4'd15);
    send_item(3'd6, 32'h0, 4'd0);
    send_item(3'd7, 32'hFFFF_FFFF, 4'd15);
    send_item(lfsm_pkg::CMD_RELEASE, 32'h0, 4'd0);
    send_item(lfsm_pkg::CMD_RELEASE, 32'h0, 4'd2);
    send_item(lfsm_pkg::CMD_ACQUIRE, 32'h0, 4'd0);
    wait_idle();

    // Highest failure limit.
    write_reg(MAX_FAIL_ADDR, 32'd255);
    fail_limit = 255;
    random_phase(250);
    wait_idle();

    // A zero limit behaves as the default.
    write_reg(MAX_FAIL_ADDR, 32'd0);
    fail_limit = 30;
    random_phase(200);
    wait_idle();

    // A random limit, with the sender draining the block between chunks.
    limit_val = $urandom_range(2, 100);
    write_reg(MAX_FAIL_ADDR, {24'($urandom_range(0, 16777215)), limit_val[7:0]});
    fail_limit = limit_val;
    for (int k = 0; k < 2; k++) begin
      random_phase(100);
      wait_idle();
    end

    // Lowest limit: one failure makes the block fatal; then acquires report fatal and publishes halt.
    write_reg(MAX_FAIL_ADDR, 32'd1);
    send_item(lfsm_pkg::CMD_FAILURE, 32'h0, 4'd0);
    send_item(lfsm_pkg::CMD_ACQUIRE, 32'h0, 4'd0);
    send_item(lfsm_pkg::CMD_PUBLISH, 32'h1111_1111, 4'd0);
    send_item(lfsm_pkg::CMD_STOP, 32'h0, 4'd0);
    send_item(lfsm_pkg::CMD_STOP, 32'h0, 4'd0);
    for (int k = 0; k < 60; k++)
      send_item(3'($urandom_range(0, 7)), $urandom(), 4'($urandom_range(0, 15)));
    wait_idle();
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
